// File: rtl/core/cpdv_pkg.sv
package cpdv_pkg;

    // Field widths fixed by the interface.
    localparam int CLASS_W = 3;
    localparam int PROB_W  = 16;
    localparam int TIME_W  = 32;
    localparam int TOTAL_W = 32;
    localparam int HITS_W  = 16;
    localparam int THR_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Class code reported when nothing is published.
    localparam logic [CLASS_W-1:0] UNKNOWN_CLASS = 3'd6;

    // Configuration register map.
    localparam int NUM_REPEAT_REGS = 6;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd6;

    localparam logic [THR_W-1:0]  DEFAULT_REPEAT  = 8'd3;
    localparam logic [THR_W-1:0]  SMALL_REPEAT    = 8'd2;
    localparam logic [TIME_W-1:0] DEFAULT_TIMEOUT = 32'd10000;

    // Reset value of each repeat threshold: indices 1 and 5 use the short run.
    function automatic logic [THR_W-1:0] repeat_reset(input int idx);
        logic [THR_W-1:0] val;
        val = DEFAULT_REPEAT;
        if (idx == 1 || idx == 5) begin
            val = SMALL_REPEAT;
        end
        return val;
    endfunction

endpackage

// File: rtl/core/cpdv_div.sv
// Restoring divider, one quotient bit per cycle. The quotient is clamped
// to the probability width.
module cpdv_div
    import cpdv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [TOTAL_W-1:0] dividend,
    input  logic [PROB_W-1:0]  divisor,
    output logic               done,
    output logic [PROB_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(TOTAL_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TOTAL_W - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TOTAL_W-1:0] quo_reg;
    logic [PROB_W:0]    rem_reg;
    logic [PROB_W-1:0]  dsr_reg;

    logic [PROB_W:0]    rem_shift;
    logic [PROB_W:0]    rem_diff;
    logic               fits;
    logic [PROB_W:0]    rem_next;
    logic [TOTAL_W-1:0] quo_next;

    always_comb begin
        rem_shift = {rem_reg[PROB_W-1:0], quo_reg[TOTAL_W-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        fits      = (rem_shift >= {1'b0, dsr_reg});
        rem_next  = fits ? rem_diff : rem_shift;
        quo_next  = {quo_reg[TOTAL_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = (|quo_reg[TOTAL_W-1:PROB_W]) ? '1 : quo_reg[PROB_W-1:0];

endmodule

// File: rtl/core/class_prediction_debounce_vote_top.sv
// An input goes through capture and update; an invalid class then goes straight to
// the result, otherwise the run and timeout decision follows. A run publish adds the
// 32-step serial divider, and a majority publish adds the one-class-per-cycle scan
// before it. One prediction at a time: the input is ready again once the result is
// in the output register. Reset (aresetn, synchronous, active low) restores default
// settings, an unknown run and no history.
module class_prediction_debounce_vote_top
    import cpdv_pkg::*;
#(
    parameter int NUM_CLASSES = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CLASS_W-1:0]    s_raw_class,
    input  logic [PROB_W-1:0]     s_raw_prob,
    input  logic [TIME_W-1:0]     s_now_ms,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CLASS_W-1:0]    m_out_class,
    output logic [PROB_W-1:0]     m_out_prob,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(NUM_CLASSES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CLASSES - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_UPDATE   = 3'd1;
    localparam logic [2:0] ST_DECIDE   = 3'd2;
    localparam logic [2:0] ST_SCAN     = 3'd3;
    localparam logic [2:0] ST_DIV_GO   = 3'd4;
    localparam logic [2:0] ST_DIV_WAIT = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0] state_reg;

    // Configuration registers.
    logic [THR_W-1:0]  repeat_reg [NUM_REPEAT_REGS];
    logic [TIME_W-1:0] timeout_reg;

    // Captured input item.
    logic [CLASS_W-1:0] cls_reg;
    logic [PROB_W-1:0]  prob_reg;
    logic [TIME_W-1:0]  now_reg;

    // Run and history state.
    logic [CLASS_W-1:0] run_class_reg;
    logic [HITS_W-1:0]  run_length_reg;
    logic [TOTAL_W-1:0] run_total_reg;
    logic [HITS_W-1:0]  hits_reg  [NUM_CLASSES];
    logic [TOTAL_W-1:0] totals_reg [NUM_CLASSES];
    logic [TIME_W-1:0]  last_publish_reg;

    // Majority scan.
    logic [IDX_W-1:0]   scan_idx_reg;
    logic [HITS_W-1:0]  best_hits_reg;
    logic [TOTAL_W-1:0] best_total_reg;
    logic [CLASS_W-1:0] best_class_reg;

    // Result being built and the output register.
    logic [CLASS_W-1:0] res_class_reg;
    logic [PROB_W-1:0]  res_prob_reg;
    logic [TOTAL_W-1:0] div_dvd_reg;
    logic [PROB_W-1:0]  div_dsr_reg;
    logic               m_valid_reg;
    logic [CLASS_W-1:0] m_class_reg;
    logic [PROB_W-1:0]  m_prob_reg;

    logic               div_start;
    logic               div_done;
    logic [PROB_W-1:0]  div_quo;

    // Combinational helpers.
    logic               cls_valid;
    logic [IDX_W-1:0]   rd_idx;
    logic [HITS_W-1:0]  hits_rd;
    logic [TOTAL_W-1:0] totals_rd;
    logic [HITS_W-1:0]  run_len_base;
    logic [TOTAL_W-1:0] run_total_base;
    logic [HITS_W-1:0]  run_len_inc;
    logic [TOTAL_W:0]   run_total_sum;
    logic [TOTAL_W-1:0] run_total_add;
    logic [HITS_W-1:0]  hits_inc;
    logic [TOTAL_W:0]   totals_sum;
    logic [TOTAL_W-1:0] totals_add;
    logic [THR_W-1:0]   thr;
    logic [TIME_W-1:0]  elapsed;
    logic               run_pass;
    logic               timeout_pass;
    logic               scan_better;
    logic               out_free;

    always_comb begin
        cls_valid = ({1'b0, cls_reg} < 4'(NUM_CLASSES));
        // One read port on the history: the scan index while scanning, else the class.
        rd_idx    = (state_reg == ST_SCAN) ? scan_idx_reg : cls_reg[IDX_W-1:0];
        hits_rd   = hits_reg[rd_idx];
        totals_rd = totals_reg[rd_idx];

        // A change of class starts a fresh run.
        run_len_base   = (run_class_reg != cls_reg) ? '0 : run_length_reg;
        run_total_base = (run_class_reg != cls_reg) ? '0 : run_total_reg;

        run_len_inc   = (&run_len_base) ? run_len_base : run_len_base + 1'b1;
        run_total_sum = {1'b0, run_total_base} + {{(TOTAL_W + 1 - PROB_W){1'b0}}, prob_reg};
        run_total_add = run_total_sum[TOTAL_W] ? '1 : run_total_sum[TOTAL_W-1:0];

        hits_inc   = (&hits_rd) ? hits_rd : hits_rd + 1'b1;
        totals_sum = {1'b0, totals_rd} + {{(TOTAL_W + 1 - PROB_W){1'b0}}, prob_reg};
        totals_add = totals_sum[TOTAL_W] ? '1 : totals_sum[TOTAL_W-1:0];

        // Classes past the register map use the default threshold.
        thr = (cls_reg < CLASS_W'(NUM_REPEAT_REGS)) ? repeat_reg[cls_reg] : DEFAULT_REPEAT;

        elapsed      = now_reg - last_publish_reg;
        run_pass     = (run_length_reg >= {{(HITS_W - THR_W){1'b0}}, thr});
        timeout_pass = (elapsed >= timeout_reg);

        // Strictly better: more hits, or equal hits and a larger total. Ties keep
        // the lower index because the scan runs upward.
        scan_better = (hits_rd != '0) &&
                      ((hits_rd > best_hits_reg) ||
                       ((hits_rd == best_hits_reg) && (totals_rd > best_total_reg)));

        out_free  = !m_valid_reg || m_ready;
        div_start = (state_reg == ST_DIV_GO);
    end

    cpdv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd_reg),
        .divisor  (div_dsr_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Configuration writes are taken in any cycle; the user must send them only while idle (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REPEAT_REGS; i++) begin
                repeat_reg[i] <= repeat_reset(i);
            end
            timeout_reg <= DEFAULT_TIMEOUT;
        end else if (cfg_valid) begin
            if (cfg_index < CFG_IDX_W'(NUM_REPEAT_REGS)) begin
                repeat_reg[cfg_index] <= cfg_data[THR_W-1:0];
            end else if (cfg_index == REG_TIMEOUT) begin
                timeout_reg <= cfg_data[TIME_W-1:0];
            end
        end
    end

    // Sequencer, run state and history.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            run_class_reg    <= UNKNOWN_CLASS;
            run_length_reg   <= '0;
            run_total_reg    <= '0;
            last_publish_reg <= '0;
            m_valid_reg      <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                hits_reg[i]   <= '0;
                totals_reg[i] <= '0;
            end
        end else begin
            // A result leaving the output register frees it, unless a new one
            // moves in at the same edge.
            if (m_valid_reg && m_ready && !((state_reg == ST_DONE) && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (!cls_valid) begin
                        // An invalid class drops the run but keeps the history.
                        run_class_reg  <= UNKNOWN_CLASS;
                        run_length_reg <= '0;
                        run_total_reg  <= '0;
                        state_reg      <= ST_DONE;
                    end else begin
                        run_class_reg  <= cls_reg;
                        run_length_reg <= run_len_inc;
                        run_total_reg  <= run_total_add;
                        hits_reg[rd_idx]   <= hits_inc;
                        totals_reg[rd_idx] <= totals_add;
                        state_reg      <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (run_pass) begin
                        state_reg <= ST_DIV_GO;
                    end else if (timeout_pass) begin
                        state_reg <= ST_SCAN;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_SCAN: begin
                    if (scan_idx_reg == LAST_IDX) begin
                        state_reg <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        // Publishing restarts the run on this class and clears history.
                        run_class_reg    <= cls_reg;
                        run_length_reg   <= '0;
                        run_total_reg    <= '0;
                        last_publish_reg <= now_reg;
                        for (int i = 0; i < NUM_CLASSES; i++) begin
                            hits_reg[i]   <= '0;
                            totals_reg[i] <= '0;
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cls_reg  <= s_raw_class;
                prob_reg <= s_raw_prob;
                now_reg  <= s_now_ms;
                res_class_reg <= UNKNOWN_CLASS;
                res_prob_reg  <= '0;
            end
            ST_DECIDE: begin
                scan_idx_reg   <= '0;
                best_hits_reg  <= '0;
                best_total_reg <= '0;
                best_class_reg <= UNKNOWN_CLASS;
                if (run_pass) begin
                    res_class_reg <= cls_reg;
                    div_dvd_reg   <= run_total_reg;
                    div_dsr_reg   <= run_length_reg;
                end
            end
            ST_SCAN: begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (scan_idx_reg == LAST_IDX) begin
                    // The last class is folded in here along with the winner so far.
                    if (scan_better) begin
                        res_class_reg <= CLASS_W'(scan_idx_reg);
                        div_dvd_reg   <= totals_rd;
                        div_dsr_reg   <= hits_rd;
                    end else begin
                        res_class_reg <= best_class_reg;
                        div_dvd_reg   <= best_total_reg;
                        div_dsr_reg   <= best_hits_reg;
                    end
                end else if (scan_better) begin
                    best_hits_reg  <= hits_rd;
                    best_total_reg <= totals_rd;
                    best_class_reg <= CLASS_W'(scan_idx_reg);
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    res_prob_reg <= div_quo;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_class_reg <= res_class_reg;
                    m_prob_reg  <= res_prob_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_out_class = m_class_reg;
    assign m_out_prob  = m_prob_reg;
    assign cfg_ready   = 1'b1;

endmodule
